// File: hw/rtl/mmx_pkg.sv
`default_nettype none
package mmx_pkg;

	localparam int NUM_MOTORS      = 4;
	localparam int IN_W            = 32;
	localparam int GAIN_W          = 40;
	localparam int GAIN_HALF_W     = GAIN_W / 2;
	localparam int PART_W          = IN_W + GAIN_HALF_W + 1;
	localparam int PROD_W          = IN_W + GAIN_W + 1;
	localparam int FRAC_DROP       = 16;
	localparam int TERM_W          = PROD_W - FRAC_DROP;
	localparam int MIX_W           = TERM_W + 2;
	localparam int SQ_W            = 48;
	localparam int SPEED_W         = SQ_W / 2;
	localparam int DUTY_W          = 16;
	localparam int QC_W            = 48;
	localparam int QC_HALF_W       = QC_W / 2;
	localparam int LC_W            = 32;
	localparam int LS_W            = LC_W + SPEED_W;
	localparam int PP_W            = QC_HALF_W + SPEED_W;
	localparam int DUTY_SUM_W      = QC_W + SQ_W + 1;
	localparam int DUTY_TOP        = 64;
	localparam int STEPS_PER_STAGE = 4;
	localparam int SQRT_STAGES     = SPEED_W / STEPS_PER_STAGE;
	localparam int MIX_STAGES      = 3;
	localparam int DUTY_STAGES     = 3;
	localparam int NUM_STAGES      = MIX_STAGES + SQRT_STAGES + DUTY_STAGES;
	localparam int APB_ADDR_W      = 6;
	localparam int APB_DATA_W      = 64;
	localparam int REG_IDX_LSB     = 3;

	typedef logic signed [IN_W-1:0] in_t;
	typedef logic [SQ_W-1:0]        sq_t;
	typedef logic [SPEED_W-1:0]     speed_t;
	typedef logic [DUTY_W-1:0]      duty_t;

	typedef enum logic [APB_ADDR_W-REG_IDX_LSB-1:0] {
		REG_THRUST_GAIN = 3'd0,
		REG_TILT_GAIN   = 3'd1,
		REG_YAW_GAIN    = 3'd2,
		REG_PWM_QUAD    = 3'd3,
		REG_PWM_LIN     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] thrust_gain;
		logic [GAIN_W-1:0] tilt_gain;
		logic [GAIN_W-1:0] yaw_gain;
		logic [QC_W-1:0]   pwm_quad_coeff;
		logic [LC_W-1:0]   pwm_lin_coeff;
	} cfg_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} sqrt_pair_t;

	// a few iterations of the bit-pair square root; first is the global step index
	function automatic sqrt_pair_t sqrt_steps(input sqrt_pair_t cur, input int first);
		sqrt_pair_t    nxt;
		logic [SQ_W-1:0] bitv;
		logic [SQ_W:0]   trial;
		nxt = cur;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			bitv  = SQ_W'(1) << (SQ_W - 2 - 2 * (first + i));
			trial = {1'b0, nxt.root} + {1'b0, bitv};
			if ({1'b0, nxt.rem} >= trial) begin
				nxt.rem  = nxt.rem - trial[SQ_W-1:0];
				nxt.root = (nxt.root >> 1) + bitv;
			end else begin
				nxt.root = nxt.root >> 1;
			end
		end
		return nxt;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mmx_mix.sv
`default_nettype none
module mmx_mix (
	input  logic              clk,
	input  logic [2:0]        en,
	input  mmx_pkg::cfg_t     cfg,
	input  mmx_pkg::in_t      x [mmx_pkg::NUM_MOTORS],
	output mmx_pkg::sq_t      sq_s3 [mmx_pkg::NUM_MOTORS]
);
	import mmx_pkg::*;

	logic signed [PART_W-1:0] ph_s1 [NUM_MOTORS];
	logic signed [PART_W-1:0] pl_s1 [NUM_MOTORS];
	logic signed [TERM_W-1:0] term_s2 [NUM_MOTORS];
	logic [GAIN_W-1:0]        gain [NUM_MOTORS];
	logic signed [PROD_W-1:0] full [NUM_MOTORS];
	logic signed [MIX_W-1:0]  mix [NUM_MOTORS];
	logic signed [MIX_W-1:0]  a1, a2, a3, a4;
	sq_t                      clamp [NUM_MOTORS];

	assign gain[0] = cfg.thrust_gain;
	assign gain[1] = cfg.tilt_gain;
	assign gain[2] = cfg.tilt_gain;
	assign gain[3] = cfg.yaw_gain;

	// stage 1: signed input times upper and lower gain halves
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < NUM_MOTORS; k++) begin
				ph_s1[k] <= x[k] * $signed({1'b0, gain[k][GAIN_W-1:GAIN_HALF_W]});
				pl_s1[k] <= x[k] * $signed({1'b0, gain[k][GAIN_HALF_W-1:0]});
			end
		end
	end

	// stage 2: recombine, arithmetic shift gives the floor
	always_comb begin
		for (int k = 0; k < NUM_MOTORS; k++) begin
			full[k] = (PROD_W'(ph_s1[k]) <<< GAIN_HALF_W) + PROD_W'(pl_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < NUM_MOTORS; k++) begin
				term_s2[k] <= full[k][PROD_W-1:FRAC_DROP];
			end
		end
	end

	// stage 3: X-frame sign pattern, clamp to Q32.16 range
	always_comb begin
		a1 = MIX_W'(term_s2[0]);
		a2 = MIX_W'(term_s2[1]);
		a3 = MIX_W'(term_s2[2]);
		a4 = MIX_W'(term_s2[3]);
		mix[0] = a1 - a2 - a3 - a4;
		mix[1] = a1 - a2 + a3 + a4;
		mix[2] = a1 + a2 + a3 - a4;
		mix[3] = a1 + a2 - a3 + a4;
		for (int k = 0; k < NUM_MOTORS; k++) begin
			if (mix[k][MIX_W-1]) begin
				clamp[k] = '0;
			end else if (|mix[k][MIX_W-2:SQ_W]) begin
				clamp[k] = '1;
			end else begin
				clamp[k] = mix[k][SQ_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < NUM_MOTORS; k++) begin
				sq_s3[k] <= clamp[k];
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mmx_sqrt.sv
`default_nettype none
module mmx_sqrt (
	input  logic                        clk,
	input  logic [mmx_pkg::SQRT_STAGES-1:0] en,
	input  mmx_pkg::sq_t                sq [mmx_pkg::NUM_MOTORS],
	output mmx_pkg::speed_t             speed [mmx_pkg::NUM_MOTORS]
);
	import mmx_pkg::*;

	sqrt_pair_t pair_s [SQRT_STAGES][NUM_MOTORS];
	sqrt_pair_t pair_in [SQRT_STAGES][NUM_MOTORS];

	for (genvar st = 0; st < SQRT_STAGES; st++) begin : g_stage
		for (genvar k = 0; k < NUM_MOTORS; k++) begin : g_lane
			if (st == 0) begin : g_first
				assign pair_in[st][k] = '{rem: sq[k], root: '0};
			end else begin : g_next
				assign pair_in[st][k] = pair_s[st-1][k];
			end

			always_ff @(posedge clk) begin
				if (en[st]) begin
					pair_s[st][k] <= sqrt_steps(pair_in[st][k], st * STEPS_PER_STAGE);
				end
			end

			if (st == SQRT_STAGES - 1) begin : g_out
				assign speed[k] = pair_s[st][k].root[SPEED_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mmx_duty.sv
`default_nettype none
module mmx_duty (
	input  logic              clk,
	input  logic [2:0]        en,
	input  mmx_pkg::cfg_t     cfg,
	input  mmx_pkg::speed_t   speed [mmx_pkg::NUM_MOTORS],
	output mmx_pkg::duty_t    duty_s12 [mmx_pkg::NUM_MOTORS],
	output mmx_pkg::speed_t   speed_s12 [mmx_pkg::NUM_MOTORS]
);
	import mmx_pkg::*;

	sq_t                   sq_s10 [NUM_MOTORS];
	logic [LS_W-1:0]       ls_s10 [NUM_MOTORS];
	speed_t                sp_s10 [NUM_MOTORS];
	logic [PP_W-1:0]       hh_s11 [NUM_MOTORS];
	logic [PP_W-1:0]       hl_s11 [NUM_MOTORS];
	logic [PP_W-1:0]       lh_s11 [NUM_MOTORS];
	logic [PP_W-1:0]       ll_s11 [NUM_MOTORS];
	logic [LS_W-1:0]       ls_s11 [NUM_MOTORS];
	speed_t                sp_s11 [NUM_MOTORS];
	logic [DUTY_SUM_W-1:0] total [NUM_MOTORS];
	duty_t                 duty [NUM_MOTORS];

	// stage 10: speed squared and linear term
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < NUM_MOTORS; k++) begin
				sq_s10[k] <= speed[k] * speed[k];
				ls_s10[k] <= cfg.pwm_lin_coeff * LS_W'(speed[k]);
				sp_s10[k] <= speed[k];
			end
		end
	end

	// stage 11: quad coefficient times speed squared as four 24x24 partials
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < NUM_MOTORS; k++) begin
				hh_s11[k] <= cfg.pwm_quad_coeff[QC_W-1:QC_HALF_W] * sq_s10[k][SQ_W-1:SPEED_W];
				hl_s11[k] <= cfg.pwm_quad_coeff[QC_W-1:QC_HALF_W] * sq_s10[k][SPEED_W-1:0];
				lh_s11[k] <= cfg.pwm_quad_coeff[QC_HALF_W-1:0] * sq_s10[k][SQ_W-1:SPEED_W];
				ll_s11[k] <= cfg.pwm_quad_coeff[QC_HALF_W-1:0] * sq_s10[k][SPEED_W-1:0];
				ls_s11[k] <= ls_s10[k];
				sp_s11[k] <= sp_s10[k];
			end
		end
	end

	// stage 12: sum, take Q0.16 out of bits 63:48, saturate on anything above
	always_comb begin
		for (int k = 0; k < NUM_MOTORS; k++) begin
			total[k] = (DUTY_SUM_W'(hh_s11[k]) << (2 * QC_HALF_W))
				+ (DUTY_SUM_W'(hl_s11[k]) << QC_HALF_W)
				+ (DUTY_SUM_W'(lh_s11[k]) << QC_HALF_W)
				+ DUTY_SUM_W'(ll_s11[k])
				+ (DUTY_SUM_W'(ls_s11[k]) << SPEED_W);
			if (|total[k][DUTY_SUM_W-1:DUTY_TOP]) begin
				duty[k] = '1;
			end else begin
				duty[k] = total[k][DUTY_TOP-1:DUTY_TOP-DUTY_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < NUM_MOTORS; k++) begin
				duty_s12[k]  <= duty[k];
				speed_s12[k] <= sp_s11[k];
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/quad_x_motor_mixer_unit.sv
// An accepted input beat passes through the mix, square-root and duty stages to its output beat.
// Throughput: one beat per cycle while the output is not stalled; the 6-stage square root (4 result bits per stage)
// and the split 48x48 duty product set the depth.
// Each stage holds its beat while downstream stalls; bubbles are squeezed out.
// Reset (arst_n low) clears all stage valid bits and the gain/coefficient registers to 0.
`default_nettype none
module quad_x_motor_mixer_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [mmx_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [mmx_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [mmx_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// thrust, roll_torque, pitch_torque, yaw_torque (32 bits each, from bit 0 up)
	input  logic [127:0]                          s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// duty_front, duty_second, duty_third, duty_fourth (16 bits each),
	// speed_front, speed_second, speed_third, speed_fourth (24 bits each)
	output logic [159:0]                          m_axis_tdata
);
	import mmx_pkg::*;

	cfg_t                  cfg_q;
	logic                  wr_en;
	reg_idx_t              wr_idx;
	logic [NUM_STAGES-1:0] valid_s;
	logic [NUM_STAGES-1:0] en;
	in_t                   x [NUM_MOTORS];
	sq_t                   sq [NUM_MOTORS];
	speed_t                speed [NUM_MOTORS];
	duty_t                 duty_out [NUM_MOTORS];
	speed_t                speed_out [NUM_MOTORS];

	// configuration port
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign wr_idx = reg_idx_t'(paddr[APB_ADDR_W-1:REG_IDX_LSB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				REG_THRUST_GAIN: cfg_q.thrust_gain    <= pwdata[GAIN_W-1:0];
				REG_TILT_GAIN:   cfg_q.tilt_gain      <= pwdata[GAIN_W-1:0];
				REG_YAW_GAIN:    cfg_q.yaw_gain       <= pwdata[GAIN_W-1:0];
				REG_PWM_QUAD:    cfg_q.pwm_quad_coeff <= pwdata[QC_W-1:0];
				REG_PWM_LIN:     cfg_q.pwm_lin_coeff  <= pwdata[LC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_THRUST_GAIN: prdata = APB_DATA_W'(cfg_q.thrust_gain);
			REG_TILT_GAIN:   prdata = APB_DATA_W'(cfg_q.tilt_gain);
			REG_YAW_GAIN:    prdata = APB_DATA_W'(cfg_q.yaw_gain);
			REG_PWM_QUAD:    prdata = APB_DATA_W'(cfg_q.pwm_quad_coeff);
			REG_PWM_LIN:     prdata = APB_DATA_W'(cfg_q.pwm_lin_coeff);
			default:         prdata = '0;
		endcase
	end

	// a stage loads when it is empty or the stage after it loads
	always_comb begin
		en[NUM_STAGES-1] = ~valid_s[NUM_STAGES-1] | m_axis_tready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = ~valid_s[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[0]) begin
				valid_s[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	assign s_axis_tready = en[0];
	assign m_axis_tvalid = valid_s[NUM_STAGES-1];

	always_comb begin
		for (int k = 0; k < NUM_MOTORS; k++) begin
			x[k] = s_axis_tdata[k*IN_W +: IN_W];
		end
	end

	mmx_mix u_mix (
		.clk   (clk),
		.en    (en[MIX_STAGES-1:0]),
		.cfg   (cfg_q),
		.x     (x),
		.sq_s3 (sq)
	);

	mmx_sqrt u_sqrt (
		.clk   (clk),
		.en    (en[MIX_STAGES+SQRT_STAGES-1:MIX_STAGES]),
		.sq    (sq),
		.speed (speed)
	);

	mmx_duty u_duty (
		.clk       (clk),
		.en        (en[NUM_STAGES-1:MIX_STAGES+SQRT_STAGES]),
		.cfg       (cfg_q),
		.speed     (speed),
		.duty_s12  (duty_out),
		.speed_s12 (speed_out)
	);

	always_comb begin
		for (int k = 0; k < NUM_MOTORS; k++) begin
			m_axis_tdata[k*DUTY_W +: DUTY_W] = duty_out[k];
			m_axis_tdata[NUM_MOTORS*DUTY_W + k*SPEED_W +: SPEED_W] = speed_out[k];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mmx_chk.sv
`default_nettype none
module mmx_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [159:0] m_axis_tdata
);

	// held output beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// with the output register empty nothing can block the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// a stopped rotor gets zero duty
	a_zero_speed_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[87:64] != 24'd0 || m_axis_tdata[15:0] == 16'd0) &&
			(m_axis_tdata[111:88] != 24'd0 || m_axis_tdata[31:16] == 16'd0) &&
			(m_axis_tdata[135:112] != 24'd0 || m_axis_tdata[47:32] == 16'd0) &&
			(m_axis_tdata[159:136] != 24'd0 || m_axis_tdata[63:48] == 16'd0))
		else $error("nonzero duty at zero speed");

	// no output beat right after reset release
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output valid out of reset");

endmodule

bind quad_x_motor_mixer_unit mmx_chk u_mmx_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import mmx_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int DRAIN_PAD        = 24;
	localparam int FIRST_UNUSED_REG = 5;
	localparam int LAST_REG_SLOT    = 7;
	localparam in_t ONE_Q24 = 32'sh0100_0000;
	localparam in_t IN_MAX  = 32'sh7FFF_FFFF;
	localparam in_t IN_MIN  = in_t'(32'h8000_0000);

	typedef struct packed {
		speed_t [NUM_MOTORS-1:0] speed;
		duty_t  [NUM_MOTORS-1:0] duty;
	} mix_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [127:0]          s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [159:0]          m_axis_tdata;

	// shadow copy of the gain and duty coefficient registers
	logic [GAIN_W-1:0] thrust_g, tilt_g, yaw_g;
	logic [QC_W-1:0]   quad_c;
	logic [LC_W-1:0]   lin_c;

	mix_result_t pending_mix_q[$];
	int          fail_cnt = 0;
	int          cycle_cnt = 0;
	int          src_idle_pct;
	int          sink_stall_pct;
	int          hold_left;

	quad_x_motor_mixer_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	// floor(x * g / 2^16), x signed Q8.24, g unsigned Q32.8
	function automatic logic signed [79:0] scaled_term(in_t x, logic [GAIN_W-1:0] g);
		logic signed [79:0] xs, gs, prod;
		xs = x;
		gs = $signed({40'd0, g});
		prod = xs * gs;
		return prod >>> FRAC_DROP;
	endfunction

	function automatic sq_t clamp_sq(logic signed [79:0] s);
		if (s < 0)
			return '0;
		if (s > $signed({32'd0, {SQ_W{1'b1}}}))
			return '1;
		return s[SQ_W-1:0];
	endfunction

	// bitwise search for the largest r with r*r <= v
	function automatic speed_t root_floor(sq_t v);
		logic [63:0] r, t, v64;
		r = '0;
		v64 = {16'd0, v};
		for (int b = SPEED_W - 1; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v64)
				r = t;
		end
		return r[SPEED_W-1:0];
	endfunction

	function automatic duty_t duty_from(speed_t sp);
		logic [127:0] q, l, s, acc;
		q = quad_c;
		l = lin_c;
		s = sp;
		acc = q * (s * s) + ((l * s) << 24);
		if (acc[127:64] != '0)
			return '1;
		return acc[63:48];
	endfunction

	function automatic mix_result_t predict_mix(in_t thr, in_t roll, in_t pitch, in_t yaw);
		logic signed [79:0] a_t, a_r, a_p, a_y;
		logic signed [79:0] mix [NUM_MOTORS];
		mix_result_t res;
		a_t = scaled_term(thr, thrust_g);
		a_r = scaled_term(roll, tilt_g);
		a_p = scaled_term(pitch, tilt_g);
		a_y = scaled_term(yaw, yaw_g);
		// X-frame sign pattern
		mix[0] = a_t - a_r - a_p - a_y;
		mix[1] = a_t - a_r + a_p + a_y;
		mix[2] = a_t + a_r + a_p - a_y;
		mix[3] = a_t + a_r - a_p + a_y;
		for (int k = 0; k < NUM_MOTORS; k++) begin
			res.speed[k] = root_floor(clamp_sq(mix[k]));
			res.duty[k]  = duty_from(res.speed[k]);
		end
		return res;
	endfunction

	function automatic logic [63:0] reg_value(logic [2:0] idx);
		case (idx)
			REG_THRUST_GAIN: return {24'd0, thrust_g};
			REG_TILT_GAIN:   return {24'd0, tilt_g};
			REG_YAW_GAIN:    return {24'd0, yaw_g};
			REG_PWM_QUAD:    return {16'd0, quad_c};
			REG_PWM_LIN:     return {32'd0, lin_c};
			default:         return '0;
		endcase
	endfunction

	function automatic int reg_width(logic [2:0] idx);
		case (idx)
			REG_PWM_QUAD: return QC_W;
			REG_PWM_LIN:  return LC_W;
			default:      return GAIN_W;
		endcase
	endfunction

	// ---------------- random values ----------------

	// random value whose bit length is picked in lo..hi
	function automatic logic [63:0] rand_len(int lo, int hi);
		int n;
		logic [63:0] v;
		n = $urandom_range(hi, lo);
		v = {$urandom, $urandom};
		return (n == 0) ? 64'd0 : v >> (64 - n);
	endfunction

	function automatic in_t rand_signed(int max_len);
		in_t m;
		m = in_t'(rand_len(0, max_len));
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic in_t rand_field();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: return IN_MAX;
					1: return IN_MIN;
					2: return '0;
					3: return -1;
					default: return 1;
				endcase
			end
			1: return in_t'($urandom);
			default: return rand_signed(31);
		endcase
	endfunction

	// mostly hover-like commands: positive thrust, smaller torques
	task automatic make_cmd(output in_t thr, output in_t roll, output in_t pitch,
			output in_t yaw);
		int tl;
		if ($urandom_range(0, 3) == 0) begin
			thr   = rand_field();
			roll  = rand_field();
			pitch = rand_field();
			yaw   = rand_field();
		end else begin
			thr   = in_t'(rand_len(20, 31));
			tl    = 31 - $urandom_range(1, 12);
			roll  = rand_signed(tl);
			pitch = rand_signed(tl);
			yaw   = rand_signed(tl);
		end
	endtask

	// ---------------- bus tasks ----------------

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, {REG_IDX_LSB{1'b0}}};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_THRUST_GAIN: thrust_g = val[GAIN_W-1:0];
			REG_TILT_GAIN:   tilt_g   = val[GAIN_W-1:0];
			REG_YAW_GAIN:    yaw_g    = val[GAIN_W-1:0];
			REG_PWM_QUAD:    quad_c   = val[QC_W-1:0];
			REG_PWM_LIN:     lin_c    = val[LC_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_reg(logic [2:0] idx, output logic [63:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, {REG_IDX_LSB{1'b0}}};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		val = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic verify_regs();
		logic [63:0] got;
		for (int i = REG_THRUST_GAIN; i <= REG_PWM_LIN; i++) begin
			read_reg(3'(i), got);
			if (got !== reg_value(3'(i))) begin
				$display("%0t: reg %0d expected %h got %h", $time, i, reg_value(3'(i)), got);
				fail_cnt++;
			end
		end
	endtask

	// ---------------- stream tasks ----------------

	task automatic send_cmd(in_t thr, in_t roll, in_t pitch, in_t yaw);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {yaw, pitch, roll, thr};
		do @(posedge clk); while (!s_axis_tready);
		pending_mix_q.push_back(predict_mix(thr, roll, pitch, yaw));
	endtask

	// drop tvalid, let every pending beat come out, then let the pipe settle
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_mix_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		mix_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_mix_q.size() == 0) begin
				$display("%0t: unexpected output beat, expected none got %h", $time,
					m_axis_tdata);
				fail_cnt++;
			end else begin
				want = pending_mix_q.pop_front();
				for (int k = 0; k < NUM_MOTORS; k++) begin
					if (got.duty[k] !== want.duty[k]) begin
						$display("%0t: duty[%0d] expected %0d got %0d", $time, k,
							want.duty[k], got.duty[k]);
						fail_cnt++;
					end
					if (got.speed[k] !== want.speed[k]) begin
						$display("%0t: speed[%0d] expected %0d got %0d", $time, k,
							want.speed[k], got.speed[k]);
						fail_cnt++;
					end
				end
			end
		end
	end

	// ---------------- tests ----------------

	// registers come out of reset at zero, so every motor sits at zero
	task automatic test_reset_state();
		verify_regs();
		repeat (6) send_cmd(rand_field(), rand_field(), rand_field(), rand_field());
		wait_idle();
	endtask

	task automatic test_directed();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		write_reg(REG_THRUST_GAIN, 64'h100);
		write_reg(REG_TILT_GAIN, 64'h200);
		write_reg(REG_YAW_GAIN, 64'h80);
		write_reg(REG_PWM_QUAD, 64'h0000_0100_0000);
		write_reg(REG_PWM_LIN, 64'h0001_0000);
		verify_regs();
		send_cmd(0, 0, 0, 0);
		send_cmd(ONE_Q24, 0, 0, 0);
		send_cmd(IN_MAX, 0, 0, 0);
		send_cmd(IN_MIN, 0, 0, 0);
		// one torque at a time shows the sign pattern
		send_cmd(IN_MAX, ONE_Q24, 0, 0);
		send_cmd(IN_MAX, -ONE_Q24, 0, 0);
		send_cmd(IN_MAX, 0, ONE_Q24, 0);
		send_cmd(IN_MAX, 0, -ONE_Q24, 0);
		send_cmd(IN_MAX, 0, 0, ONE_Q24);
		send_cmd(IN_MAX, 0, 0, -ONE_Q24);
		// tiny negative terms floor to -1
		send_cmd(1, -1, 0, 0);
		send_cmd(-1, -1, -1, -1);
		send_cmd(IN_MAX, IN_MAX, IN_MAX, IN_MAX);
		send_cmd(IN_MIN, IN_MIN, IN_MIN, IN_MIN);
		wait_idle();

		// full-scale registers; bits above each width must be dropped
		for (int i = REG_THRUST_GAIN; i <= REG_PWM_LIN; i++)
			write_reg(3'(i), '1);
		verify_regs();
		send_cmd(IN_MAX, 0, 0, 0);
		send_cmd(IN_MIN, 0, 0, 0);
		send_cmd(1, 0, 0, 0);
		send_cmd(IN_MAX, IN_MAX, IN_MAX, IN_MAX);
		send_cmd(IN_MIN, IN_MIN, IN_MIN, IN_MIN);
		send_cmd(IN_MAX, IN_MIN, IN_MAX, IN_MIN);
		wait_idle();
	endtask

	task automatic test_random_traffic(int src_pct, int sink_pct, int n_items);
		logic [63:0] junk;
		in_t thr, roll, pitch, yaw;
		int burst_left;
		for (int i = REG_THRUST_GAIN; i <= REG_PWM_LIN; i++) begin
			junk = {$urandom, $urandom};
			write_reg(3'(i), (junk << reg_width(3'(i))) | rand_len(0, reg_width(3'(i))));
		end
		// unmapped slot must not disturb anything
		write_reg(3'($urandom_range(LAST_REG_SLOT, FIRST_UNUSED_REG)), {$urandom, $urandom});
		verify_regs();
		burst_left = 0;
		for (int i = 0; i < n_items; i++) begin
			if (burst_left == 0 && $urandom_range(0, 29) == 0)
				burst_left = $urandom_range(10, 30);
			src_idle_pct   = (burst_left > 0) ? 0 : src_pct;
			sink_stall_pct = (burst_left > 0) ? 0 : sink_pct;
			if (burst_left > 0)
				burst_left--;
			make_cmd(thr, roll, pitch, yaw);
			send_cmd(thr, roll, pitch, yaw);
			if (i == n_items / 2)
				wait_idle();
		end
		wait_idle();
	endtask

	// sink holds off for a long stretch while beats keep coming
	task automatic test_backpressure();
		in_t thr, roll, pitch, yaw;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_left      = 300;
		repeat (80) begin
			make_cmd(thr, roll, pitch, yaw);
			send_cmd(thr, roll, pitch, yaw);
		end
		wait_idle();
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		hold_left      = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		thrust_g       = '0;
		tilt_g         = '0;
		yaw_g          = '0;
		quad_c         = '0;
		lin_c          = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed();
		test_random_traffic(0, 0, 175);
		test_backpressure();
		test_random_traffic(77, 0, 175);
		test_random_traffic(0, 77, 175);
		test_random_traffic(32, 32, 175);

		if (fail_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
